// ----- sv/rcsfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsfr_pkg
// Types and fixed constants of the serial RC frame receiver.
// ----------------------------------------------------------------------------
package rcsfr_pkg;

  localparam int FRAME_BYTES   = 32;
  localparam int BASE_CHANNELS = 14;
  localparam int ADDR_W        = $clog2(FRAME_BYTES);

  localparam logic [7:0] SERVO_LENGTH     = 8'd32;
  localparam logic [7:0] TLM_LENGTH       = 8'd4;
  localparam logic [7:0] WORD_HEADER      = 8'h55;
  localparam logic [5:0] TLM_BYTES        = 6'd4;
  localparam logic [5:0] WORD_FRAME_BYTES = 6'd31;
  localparam logic [3:0] SERVO_NIBBLE     = 4'h4;
  localparam logic [7:0] GAP_MS_RESET     = 8'd3;
  localparam logic [7:0] IDLE_MAX         = 8'hFF;

  typedef enum logic [2:0] {
    PH_LENGTH,
    PH_COMMAND,
    PH_DATA,
    PH_CHECK_LOW,
    PH_CHECK_HIGH
  } rx_phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_SINGLE,
    SQ_FETCH,
    SQ_CAPTURE,
    SQ_EMIT
  } seq_state_t;

  typedef enum logic [1:0] {
    KIND_CHANNEL,
    KIND_TLM_REQUEST,
    KIND_IGNORED,
    KIND_CHECK_ERROR
  } kind_t;

endpackage

// ----- sv/rc_serial_frame_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_serial_frame_receiver
// Receiver-side frame parser for a serial RC link with two frame formats.
// ----------------------------------------------------------------------------
// Usage: each request on the item channel (item_valid, item_stall) is either a
// received byte (cmd low) or a one millisecond tick (cmd high). A byte or tick
// that does not complete a frame is taken with no stall and produces nothing.
// The byte that completes a frame starts a small sequencer; item_stall stays
// high until every result of that frame has been placed in the output register.
// Results leave on the result channel (result_valid, result_stall); the output
// register holds a result until it is taken, so a stalled receiver simply
// pauses the sequencer. A checksum error, telemetry request or ignored frame
// gives one result, loaded from the SQ_SINGLE state. A servo frame gives its
// channels from the frame store through one read port and one address adder:
// a word channel costs two reads, each a fetch and a capture state, then an
// emit state; an expansion channel costs three reads and an emit state.
// Reset (rst, synchronous) returns the parser to hunting for a start byte,
// clears both frame counters and sets gap_ms to 3; the frame store itself is
// not cleared. gap_ms is written through cfg_wr_en and cfg_wr_data and must
// only be changed while the block is idle.
// ----------------------------------------------------------------------------
module rc_serial_frame_receiver
  import rcsfr_pkg::*;
#(
  parameter int ALL_CHANNELS = 18
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // Item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        cmd,
  input  logic [7:0]  rx_byte,
  // Result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic        frame_format,
  output logic [4:0]  chan_index,
  output logic [15:0] chan_value,
  output logic [3:0]  tlm_command,
  output logic [3:0]  tlm_address,
  output logic [15:0] good_frames,
  output logic [15:0] error_frames,
  output logic        last
);

  localparam logic [4:0] LAST_CHAN = 5'(ALL_CHANNELS - 1);
  localparam logic [4:0] BASE_CHAN = 5'(BASE_CHANNELS);

  // Receive state
  logic [7:0]        gap_ms;
  rx_phase_t         rx_phase, rx_phase_next, phase_eff;
  logic [ADDR_W-1:0] write_pos, write_pos_next, store_pos;
  logic [15:0]       running_sum, running_sum_next, sum_base, sum_addend;
  logic [7:0]        check_low, check_low_next;
  logic              format_flag, format_flag_next, format_eff;
  logic [5:0]        frame_length, frame_length_next;
  logic [7:0]        idle_ms, idle_ms_next;
  logic [15:0]       good_count, good_count_next;
  logic [15:0]       error_count, error_count_next;
  logic [7:0]        cmd_byte, cmd_byte_next;
  logic              item_take, byte_take, tick_take, store_en, finish, is_start;

  // Frame store
  logic [7:0]        frame_store [FRAME_BYTES];
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] rd_addr;

  // Sequencer
  seq_state_t        seq, seq_next;
  logic [4:0]        ch, ch_next;
  logic [1:0]        step, step_next;
  logic [7:0]        pick [3];
  kind_t             single_kind, single_kind_next;
  logic              out_free, load_out, is_exp, check_ok, servo;
  logic [15:0]       expected;
  logic [1:0]        exp_idx, last_step;
  logic [ADDR_W-1:0] frame_off;
  logic [1:0]        kind_next;
  logic [4:0]        chan_index_next;
  logic [15:0]       chan_value_next;
  logic [3:0]        tlm_command_next, tlm_address_next;
  logic              last_next;

  assign item_stall = (seq != SQ_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign byte_take  = item_take && !cmd;
  assign tick_take  = item_take && cmd;
  assign out_free   = !result_valid || !result_stall;

  // --------------------------------------------------------------------------
  // Byte parsing. A gap in a frame sends the parser back to hunting before the
  // byte is looked at, so the same byte may open a new frame.
  // --------------------------------------------------------------------------
  assign phase_eff = (rx_phase != PH_LENGTH && idle_ms >= gap_ms) ? PH_LENGTH : rx_phase;
  assign is_start  = (rx_byte == SERVO_LENGTH) || (rx_byte == TLM_LENGTH) ||
                     (rx_byte == WORD_HEADER);
  assign store_pos  = (phase_eff == PH_LENGTH) ? '0 : write_pos;
  assign sum_base   = (phase_eff == PH_LENGTH) ? 16'h0000 : running_sum;
  assign format_eff = (phase_eff == PH_LENGTH) ? (rx_byte == WORD_HEADER) : format_flag;

  // The word-sum format accumulates its checksum as bytes arrive: odd
  // positions are low bytes, even positions past the header are high bytes.
  always_comb begin
    if (!format_eff) begin
      sum_addend = {8'h00, rx_byte};
    end else if (store_pos == '0) begin
      sum_addend = 16'h0000;
    end else if (store_pos[0]) begin
      sum_addend = {8'h00, rx_byte};
    end else begin
      sum_addend = {rx_byte, 8'h00};
    end
  end

  always_comb begin
    rx_phase_next     = rx_phase;
    write_pos_next    = write_pos;
    running_sum_next  = running_sum;
    check_low_next    = check_low;
    format_flag_next  = format_flag;
    frame_length_next = frame_length;
    idle_ms_next      = idle_ms;
    cmd_byte_next     = cmd_byte;
    store_en          = 1'b0;
    finish            = 1'b0;
    if (tick_take) begin
      if (idle_ms != IDLE_MAX) begin
        idle_ms_next = idle_ms + 8'd1;
      end
    end else if (byte_take) begin
      idle_ms_next  = 8'd0;
      rx_phase_next = phase_eff;
      case (phase_eff)
        PH_LENGTH: begin
          if (is_start) begin
            store_en          = 1'b1;
            format_flag_next  = (rx_byte == WORD_HEADER);
            frame_length_next = (rx_byte == WORD_HEADER) ? WORD_FRAME_BYTES : rx_byte[5:0];
            rx_phase_next     = (rx_byte == WORD_HEADER) ? PH_DATA : PH_COMMAND;
          end
        end
        PH_COMMAND, PH_DATA: begin
          store_en      = 1'b1;
          rx_phase_next = ({1'b0, store_pos + 5'd1} == frame_length - 6'd2) ?
                          PH_CHECK_LOW : PH_DATA;
        end
        PH_CHECK_LOW: begin
          check_low_next = rx_byte;
          rx_phase_next  = PH_CHECK_HIGH;
        end
        PH_CHECK_HIGH: begin
          finish        = 1'b1;
          rx_phase_next = PH_LENGTH;
        end
        default: begin
          rx_phase_next = PH_LENGTH;
        end
      endcase
      if (store_en) begin
        write_pos_next   = store_pos + 5'd1;
        running_sum_next = sum_base + sum_addend;
        if (store_pos == 5'd1) begin
          cmd_byte_next = rx_byte;
        end
      end
    end
  end

  // Frame decision on the final checksum byte
  assign expected = format_flag ? running_sum : ~running_sum;
  assign check_ok = (expected == {rx_byte, check_low});
  assign servo    = format_flag || (cmd_byte[7:4] == SERVO_NIBBLE);

  always_comb begin
    good_count_next  = good_count;
    error_count_next = error_count;
    if (finish) begin
      if (check_ok) begin
        good_count_next = good_count + 16'd1;
      end else begin
        error_count_next = error_count + 16'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Channel read-out: one address adder feeds the single store read port.
  // --------------------------------------------------------------------------
  assign is_exp    = (ch >= BASE_CHAN);
  assign exp_idx   = 2'(ch - BASE_CHAN);
  assign frame_off = format_flag ? 5'd1 : 5'd2;
  assign last_step = is_exp ? 2'd2 : 2'd1;

  always_comb begin
    if (is_exp) begin
      rd_addr = frame_off + 5'd1 + {2'b00, exp_idx, 1'b0} + {1'b0, exp_idx, 2'b00} +
                {2'b00, step, 1'b0};
    end else begin
      rd_addr = frame_off + {ch[3:0], 1'b0} + {3'b000, step};
    end
  end

  always_comb begin
    seq_next         = seq;
    ch_next          = ch;
    step_next        = step;
    single_kind_next = single_kind;
    load_out         = 1'b0;
    kind_next        = KIND_CHANNEL;
    chan_index_next  = 5'd0;
    chan_value_next  = 16'h0000;
    tlm_command_next = 4'h0;
    tlm_address_next = 4'h0;
    last_next        = 1'b1;
    case (seq)
      SQ_IDLE: begin
        if (finish) begin
          if (!check_ok) begin
            single_kind_next = KIND_CHECK_ERROR;
            seq_next         = SQ_SINGLE;
          end else if (servo) begin
            ch_next   = 5'd0;
            step_next = 2'd0;
            seq_next  = SQ_FETCH;
          end else if (cmd_byte[3:0] != 4'h0 && frame_length == TLM_BYTES) begin
            single_kind_next = KIND_TLM_REQUEST;
            seq_next         = SQ_SINGLE;
          end else begin
            single_kind_next = KIND_IGNORED;
            seq_next         = SQ_SINGLE;
          end
        end
      end
      SQ_SINGLE: begin
        kind_next = single_kind;
        if (single_kind == KIND_TLM_REQUEST) begin
          tlm_command_next = cmd_byte[7:4];
          tlm_address_next = cmd_byte[3:0];
        end
        if (out_free) begin
          load_out = 1'b1;
          seq_next = SQ_IDLE;
        end
      end
      SQ_FETCH: begin
        seq_next = SQ_CAPTURE;
      end
      SQ_CAPTURE: begin
        if (step == last_step) begin
          seq_next = SQ_EMIT;
        end else begin
          step_next = step + 2'd1;
          seq_next  = SQ_FETCH;
        end
      end
      SQ_EMIT: begin
        kind_next       = KIND_CHANNEL;
        chan_index_next = ch;
        chan_value_next = is_exp ? {4'h0, pick[2][7:4], pick[1][7:4], pick[0][7:4]} :
                                   {pick[1], pick[0]};
        last_next       = (ch == LAST_CHAN);
        if (out_free) begin
          load_out  = 1'b1;
          step_next = 2'd0;
          if (ch == LAST_CHAN) begin
            seq_next = SQ_IDLE;
          end else begin
            ch_next  = ch + 5'd1;
            seq_next = SQ_FETCH;
          end
        end
      end
      default: begin
        seq_next = SQ_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (store_en) begin
      frame_store[store_pos] <= rx_byte;
    end
    rd_data <= frame_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ms       <= GAP_MS_RESET;
      rx_phase     <= PH_LENGTH;
      write_pos    <= '0;
      running_sum  <= 16'h0000;
      check_low    <= 8'h00;
      format_flag  <= 1'b0;
      frame_length <= 6'd0;
      idle_ms      <= 8'd0;
      good_count   <= 16'h0000;
      error_count  <= 16'h0000;
      seq          <= SQ_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        gap_ms <= cfg_wr_data;
      end
      rx_phase     <= rx_phase_next;
      write_pos    <= write_pos_next;
      running_sum  <= running_sum_next;
      check_low    <= check_low_next;
      format_flag  <= format_flag_next;
      frame_length <= frame_length_next;
      idle_ms      <= idle_ms_next;
      good_count   <= good_count_next;
      error_count  <= error_count_next;
      seq          <= seq_next;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_byte    <= cmd_byte_next;
    ch          <= ch_next;
    step        <= step_next;
    single_kind <= single_kind_next;
    if (seq == SQ_CAPTURE) begin
      pick[step] <= rd_data;
    end
    if (load_out) begin
      kind         <= kind_next;
      frame_format <= format_flag;
      chan_index   <= chan_index_next;
      chan_value   <= chan_value_next;
      tlm_command  <= tlm_command_next;
      tlm_address  <= tlm_address_next;
      good_frames  <= good_count;
      error_frames <= error_count;
      last         <= last_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Only the last channel of a servo frame may close the frame's results.
  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_CHANNEL && last |-> chan_index == LAST_CHAN)
    else $error("last set on a channel other than the final one");

  // Every non-channel result is the only result of its frame.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind != KIND_CHANNEL |-> last && chan_value == 16'h0000)
    else $error("single result without last or with a channel value");

  // The error count moves only on a byte taken from the item channel.
  a_error_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && error_count != $past(error_count) |-> $past(byte_take))
    else $error("error count changed without a received byte");

  // While the sequencer reads the store, the write side stays put.
  a_store_quiet: assert property (@(posedge clk) disable iff (rst)
    seq != SQ_IDLE |=> $stable(write_pos))
    else $error("frame store written during read-out");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the serial RC frame receiver.
// ----------------------------------------------------------------------------
// Requests (received bytes and millisecond ticks) go into the block, and the
// results it returns are compared with a behavioural predictor that runs on
// every accepted request. The run opens with a short table of hand-made
// requests. Randomised servo, word-sum and telemetry frames follow, with
// corrupted checksums and gaps that abort frames, under several gap settings.
// Both sides idle in random bursts. The receiver also holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import rcsfr_pkg::*;

  localparam int SERVO_CHANNELS  = 18;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int SETTLE_CYCLES   = 120;
  localparam int DRAIN_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int REPORT_LIMIT    = 10;
  localparam int DIRECTED_ROWS   = 24;

  // One result as the block presents it, field for field.
  typedef struct packed {
    kind_t       kind;
    logic        fmt;
    logic [4:0]  idx;
    logic [15:0] val;
    logic [3:0]  tcmd;
    logic [3:0]  tadr;
    logic [15:0] good;
    logic [15:0] err;
    logic        last;
  } frame_result_t;

  // A row of the opening table. Where typed is set, the result of that
  // request is written out by hand rather than taken from the predictor.
  typedef struct packed {
    logic          tick;
    logic [7:0]    data;
    logic          typed;
    frame_result_t res;
  } directed_row_t;

  localparam frame_result_t NO_RESULT =
    '{KIND_CHANNEL, 1'b0, 5'd0, 16'd0, 4'd0, 4'd0, 16'd0, 16'd0, 1'b0};

  // Short frames only: unknown start bytes, a good telemetry request, a bad
  // checksum, a request with address zero (reported as ignored) and a frame
  // broken by a gap whose next byte starts a fresh frame.
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b1, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 8'hFF, 1'b0, NO_RESULT},
    '{1'b0, 8'h04, 1'b0, NO_RESULT},
    '{1'b0, 8'h21, 1'b0, NO_RESULT},
    '{1'b0, 8'hDA, 1'b0, NO_RESULT},
    '{1'b0, 8'hFF, 1'b1,
      '{KIND_TLM_REQUEST, 1'b0, 5'd0, 16'd0, 4'h2, 4'h1, 16'd1, 16'd0, 1'b1}},
    '{1'b0, 8'h04, 1'b0, NO_RESULT},
    '{1'b0, 8'hF0, 1'b0, NO_RESULT},
    '{1'b0, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 8'h00, 1'b1,
      '{KIND_CHECK_ERROR, 1'b0, 5'd0, 16'd0, 4'h0, 4'h0, 16'd1, 16'd1, 1'b1}},
    '{1'b0, 8'h04, 1'b0, NO_RESULT},
    '{1'b0, 8'hF0, 1'b0, NO_RESULT},
    '{1'b0, 8'h0B, 1'b0, NO_RESULT},
    '{1'b0, 8'hFF, 1'b1,
      '{KIND_IGNORED, 1'b0, 5'd0, 16'd0, 4'h0, 4'h0, 16'd2, 16'd1, 1'b1}},
    '{1'b0, 8'h04, 1'b0, NO_RESULT},
    '{1'b0, 8'h8F, 1'b0, NO_RESULT},
    '{1'b1, 8'h5A, 1'b0, NO_RESULT},
    '{1'b1, 8'hA5, 1'b0, NO_RESULT},
    '{1'b1, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 8'h04, 1'b0, NO_RESULT},
    '{1'b0, 8'h3F, 1'b0, NO_RESULT},
    '{1'b0, 8'hBC, 1'b0, NO_RESULT},
    '{1'b0, 8'hFF, 1'b1,
      '{KIND_TLM_REQUEST, 1'b0, 5'd0, 16'd0, 4'h3, 4'hF, 16'd3, 16'd1, 1'b1}}
  };

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_wr_en    = 1'b0;
  logic [7:0]  cfg_wr_data  = 8'd0;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  logic        cmd          = 1'b0;
  logic [7:0]  rx_byte      = 8'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  kind;
  logic        frame_format;
  logic [4:0]  chan_index;
  logic [15:0] chan_value;
  logic [3:0]  tlm_command;
  logic [3:0]  tlm_address;
  logic [15:0] good_frames;
  logic [15:0] error_frames;
  logic        last;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rc_serial_frame_receiver #(
    .ALL_CHANNELS (SERVO_CHANNELS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .rx_byte      (rx_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .frame_format (frame_format),
    .chan_index   (chan_index),
    .chan_value   (chan_value),
    .tlm_command  (tlm_command),
    .tlm_address  (tlm_address),
    .good_frames  (good_frames),
    .error_frames (error_frames),
    .last         (last)
  );

  // --------------------------------------------------------------------------
  // Predictor state. It mirrors the parser: hunt phase, frame store, running
  // byte sum, checksum low byte, idle tick count and both frame counters.
  // The written mask records which store entries hold real data since reset.
  // --------------------------------------------------------------------------
  rx_phase_t     ph;
  logic [7:0]    store [FRAME_BYTES];
  logic [31:0]   written;
  logic [4:0]    wpos;
  logic [15:0]   rsum;
  logic [7:0]    chk_lo;
  logic          fmt_flag;
  logic [5:0]    flen;
  logic [7:0]    idle;
  logic [15:0]   good_cnt;
  logic [15:0]   err_cnt;
  logic [7:0]    gap_cfg;

  frame_result_t fresh_results [$];
  frame_result_t frame_results_due [$];

  // Set by the sender alongside each request and read when it is accepted.
  logic          item_typed = 1'b0;
  frame_result_t item_typed_res = NO_RESULT;

  logic          send_idle_on  = 1'b0;
  logic          stall_idle_on = 1'b0;
  logic          quiet_tail    = 1'b0;

  int            fail_count        = 0;
  int            requests_taken    = 0;
  int            ticks_taken       = 0;
  int            results_checked   = 0;
  int            predicted_results = 0;
  int            stuck_edges       = 0;

  task automatic queue_result(input kind_t k, input logic [4:0] idx,
                              input logic [15:0] val, input logic [3:0] tc,
                              input logic [3:0] ta, input logic lst);
    fresh_results.push_back('{k, fmt_flag, idx, val, tc, ta, good_cnt, err_cnt, lst});
  endtask

  task automatic store_byte(input logic [7:0] b);
    store[wpos]   = b;
    written[wpos] = 1'b1;
    wpos          = wpos + 5'd1;
    rsum          = rsum + 16'(b);
  endtask

  // Advances the predictor by one accepted request and leaves the results
  // that it causes in fresh_results.
  task automatic parse_rx_item(input logic tick, input logic [7:0] b);
    logic [15:0] sum;
    logic [15:0] got;
    logic [7:0]  cb;
    int          i;
    int          base;
    if (tick) begin
      if (idle != IDLE_MAX) idle = idle + 8'd1;
      return;
    end
    // A long enough silence inside a frame sends the parser back to the hunt;
    // the byte itself is then treated as a possible start byte.
    if (ph != PH_LENGTH && idle >= gap_cfg) ph = PH_LENGTH;
    idle = 8'd0;
    case (ph)
      PH_LENGTH: begin
        if (b == SERVO_LENGTH || b == TLM_LENGTH || b == WORD_HEADER) begin
          fmt_flag = (b == WORD_HEADER);
          flen     = (b == WORD_HEADER) ? WORD_FRAME_BYTES : b[5:0];
          ph       = (b == WORD_HEADER) ? PH_DATA : PH_COMMAND;
          wpos     = 5'd0;
          rsum     = 16'd0;
          store_byte(b);
        end
      end
      PH_COMMAND: begin
        store_byte(b);
        ph = ({1'b0, wpos} == flen - 6'd2) ? PH_CHECK_LOW : PH_DATA;
      end
      PH_DATA: begin
        store_byte(b);
        if ({1'b0, wpos} == flen - 6'd2) ph = PH_CHECK_LOW;
      end
      PH_CHECK_LOW: begin
        chk_lo = b;
        ph     = PH_CHECK_HIGH;
      end
      PH_CHECK_HIGH: begin
        ph  = PH_LENGTH;
        got = {b, chk_lo};
        if (!fmt_flag) begin
          sum = 16'hFFFF - rsum;
        end else begin
          sum = 16'd0;
          for (i = 1; i < int'(wpos); i += 2) sum += {store[5'(i + 1)], store[5'(i)]};
        end
        if (sum != got) begin
          err_cnt = err_cnt + 16'd1;
          queue_result(KIND_CHECK_ERROR, 5'd0, 16'd0, 4'd0, 4'd0, 1'b1);
          return;
        end
        good_cnt = good_cnt + 16'd1;
        cb       = store[1];
        if (fmt_flag || cb[7:4] == SERVO_NIBBLE) begin
          // Servo data: little-endian words, then four 12-bit channels built
          // from the high nibbles of every second byte.
          base = fmt_flag ? 1 : 2;
          for (i = 0; i < BASE_CHANNELS; i++) begin
            queue_result(KIND_CHANNEL, 5'(i),
                         {store[5'(base + 2 * i + 1)], store[5'(base + 2 * i)]},
                         4'd0, 4'd0, 1'b0);
          end
          for (i = BASE_CHANNELS; i < SERVO_CHANNELS; i++) begin
            queue_result(KIND_CHANNEL, 5'(i),
                         {4'h0, store[5'(base + 5 + 6 * (i - BASE_CHANNELS))][7:4],
                          store[5'(base + 3 + 6 * (i - BASE_CHANNELS))][7:4],
                          store[5'(base + 1 + 6 * (i - BASE_CHANNELS))][7:4]},
                         4'd0, 4'd0, i == SERVO_CHANNELS - 1);
          end
        end else if (cb[3:0] != 4'd0 && flen == TLM_BYTES) begin
          queue_result(KIND_TLM_REQUEST, 5'd0, 16'd0, cb[7:4], cb[3:0], 1'b1);
        end else begin
          queue_result(KIND_IGNORED, 5'd0, 16'd0, 4'd0, 4'd0, 1'b1);
        end
      end
      default: ph = PH_LENGTH;
    endcase
  endtask

  // True when this byte would close a good short frame carrying the servo
  // command while part of the store has never been written since reset. The
  // block would then emit channels from undefined store entries, so the
  // sender flips a bit of the checksum instead.
  function automatic logic reads_unwritten(input logic [7:0] b);
    if (ph != PH_CHECK_HIGH || idle >= gap_cfg || fmt_flag || flen != TLM_BYTES) return 1'b0;
    if (store[1][7:4] != SERVO_NIBBLE) return 1'b0;
    return ((16'hFFFF - rsum) == {b, chk_lo}) && !(&written[29:2]);
  endfunction

  task automatic note_failure(input string what, input frame_result_t due,
                              input frame_result_t seen);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("ERROR %s at %0t ns", what, $time);
      $display("  expected kind=%0d fmt=%0d idx=%0d val=%h cmd=%h adr=%h good=%0d err=%0d last=%0d",
               due.kind, due.fmt, due.idx, due.val, due.tcmd, due.tadr, due.good, due.err,
               due.last);
      $display("  actual   kind=%0d fmt=%0d idx=%0d val=%h cmd=%h adr=%h good=%0d err=%0d last=%0d",
               seen.kind, seen.fmt, seen.idx, seen.val, seen.tcmd, seen.tadr, seen.good,
               seen.err, seen.last);
    end
  endtask

  // --------------------------------------------------------------------------
  // Port observer. Everything is sampled at the rising edge, before the block's
  // own registers move. A taken result is compared with the oldest one due;
  // a taken request then advances the predictor. The two never race, since a
  // request's results pass through the sequencer and the output register first.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : port_observer
    frame_result_t seen;
    frame_result_t due;
    string         bad;
    if (rst) begin
      // The frame store is not cleared by reset, so neither is the mirror.
      ph       = PH_LENGTH;
      written  = '0;
      wpos     = 5'd0;
      rsum     = 16'd0;
      chk_lo   = 8'd0;
      fmt_flag = 1'b0;
      flen     = 6'd0;
      idle     = 8'd0;
      good_cnt = 16'd0;
      err_cnt  = 16'd0;
      gap_cfg  = GAP_MS_RESET;
    end else begin
      if (cfg_wr_en) gap_cfg = cfg_wr_data;
      if (result_valid && !result_stall) begin
        seen = '{kind_t'(kind), frame_format, chan_index, chan_value, tlm_command,
                 tlm_address, good_frames, error_frames, last};
        results_checked++;
        if (frame_results_due.size() == 0) begin
          note_failure("result arrived with nothing due", NO_RESULT, seen);
        end else begin
          due = frame_results_due.pop_front();
          bad = "";
          if (seen.kind !== due.kind) bad = {bad, " kind"};
          if (seen.fmt  !== due.fmt)  bad = {bad, " frame_format"};
          if (seen.idx  !== due.idx)  bad = {bad, " chan_index"};
          if (seen.val  !== due.val)  bad = {bad, " chan_value"};
          if (seen.tcmd !== due.tcmd) bad = {bad, " tlm_command"};
          if (seen.tadr !== due.tadr) bad = {bad, " tlm_address"};
          if (seen.good !== due.good) bad = {bad, " good_frames"};
          if (seen.err  !== due.err)  bad = {bad, " error_frames"};
          if (seen.last !== due.last) bad = {bad, " last"};
          if (bad != "") note_failure({"wrong field(s):", bad}, due, seen);
        end
      end
      if (item_valid && !item_stall) begin
        requests_taken++;
        if (cmd) ticks_taken++;
        fresh_results.delete();
        parse_rx_item(cmd, rx_byte);
        if (item_typed) begin
          frame_results_due.push_back(item_typed_res);
          predicted_results++;
        end else begin
          foreach (fresh_results[n]) frame_results_due.push_back(fresh_results[n]);
          predicted_results += fresh_results.size();
        end
      end
    end
  end

  // Ends a run that has stopped moving on both channels.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      stuck_edges = 0;
    end else begin
      stuck_edges = stuck_edges + 1;
    end
    if (stuck_edges >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("rc_serial_frame_receiver: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side. Straight after reset the receiver refuses results for a long
  // stretch while the sender carries on, so the output register fills and the
  // block has to stall its request input. After that it stalls in random
  // bursts, with calm spells in between, and not at all near the end.
  // --------------------------------------------------------------------------
  initial begin : result_side
    int burst;
    burst = 0;
    while (rst) @(negedge clk);
    result_stall <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(negedge clk);
    result_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 49) == 0) stall_idle_on = !stall_idle_on;
      if (quiet_tail) begin
        result_stall <= 1'b0;
      end else if (burst > 0) begin
        result_stall <= 1'b1;
        burst--;
      end else if (stall_idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 13);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Offers one request from a falling edge and returns at the falling edge
  // after it was taken. Valid stays high between back-to-back requests.
  task automatic send_item(input logic tick, input logic [7:0] b, input logic has_typed,
                           input frame_result_t typed);
    logic [7:0] data;
    data = b;
    if ($urandom_range(0, 11) == 0) send_idle_on = !send_idle_on;
    if (send_idle_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    if (!tick && reads_unwritten(data)) data = data ^ 8'h01;
    item_typed     = has_typed;
    item_typed_res = typed;
    item_valid <= 1'b1;
    cmd        <= tick;
    rx_byte    <= data;
    do @(posedge clk); while (!(item_valid && !item_stall));
    @(negedge clk);
  endtask

  // The gap register is only touched with no result outstanding and the
  // parser given time to finish whatever it was doing.
  task automatic set_gap(input logic [7:0] g);
    item_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= g;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random frames: mostly well-formed servo, word-sum and telemetry frames with
  // random content, some with a spoilt checksum, some cut by a gap under the
  // narrow gap settings, plus a little noise. Ticks shorter than the gap are
  // sprinkled between bytes.
  task automatic run_random(input int byte_target, input int result_target);
    logic [7:0]  frame [$];
    logic [15:0] chk;
    int          sent;
    int          pick;
    int          cut;
    int          n;
    int          j;
    sent = 0;
    while (sent < byte_target || predicted_results < result_target) begin
      frame.delete();
      chk  = 16'd0;
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        frame.push_back(SERVO_LENGTH);
        frame.push_back(($urandom_range(0, 3) != 0) ? {SERVO_NIBBLE, 4'($urandom)}
                                                     : 8'($urandom));
        repeat (28) frame.push_back(8'($urandom));
        foreach (frame[k]) chk += 16'(frame[k]);
        chk = 16'hFFFF - chk;
      end else if (pick <= 5) begin
        frame.push_back(WORD_HEADER);
        repeat (28) frame.push_back(8'($urandom));
        for (j = 1; j < 29; j += 2) chk += {frame[j + 1], frame[j]};
      end else if (pick <= 8) begin
        frame.push_back(TLM_LENGTH);
        case ($urandom_range(0, 2))
          0:       frame.push_back({SERVO_NIBBLE, 4'($urandom)});
          1:       frame.push_back({4'($urandom), 4'h0});
          default: frame.push_back(8'($urandom));
        endcase
        chk = 16'hFFFF - 16'(TLM_LENGTH) - 16'(frame[1]);
      end
      if (pick <= 8) begin
        if ($urandom_range(0, 5) == 0) chk ^= 16'($urandom_range(1, 65535));
        frame.push_back(chk[7:0]);
        frame.push_back(chk[15:8]);
        sent += frame.size();
      end else begin
        repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
      end
      cut = (frame.size() > 1 && gap_cfg <= 8'd8 && $urandom_range(0, 4) == 0) ?
            $urandom_range(1, frame.size() - 1) : -1;
      foreach (frame[k]) begin
        if (k == cut) begin
          // A cut keeps the line silent for at least the gap.
          n = gap_cfg + $urandom_range(0, 3);
        end else if (gap_cfg > 1 && $urandom_range(0, 9) == 0) begin
          n = $urandom_range(1, (gap_cfg > 5) ? 4 : gap_cfg - 1);
        end else begin
          n = 0;
        end
        repeat (n) send_item(1'b1, 8'($urandom), 1'b0, NO_RESULT);
        send_item(1'b0, frame[k], 1'b0, NO_RESULT);
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_item(DIRECTED[r].tick, DIRECTED[r].data, DIRECTED[r].typed, DIRECTED[r].res);
    end

    // Widest gap first, then the narrowest one under which frames still complete.
    set_gap(8'd255);
    run_random(24, 0);
    set_gap(8'd1);
    run_random(16, 0);

    // With a zero gap every byte inside a frame sends the parser back to the
    // hunt, so start bytes open frames that never complete.
    set_gap(8'd0);
    repeat (16) begin
      case ($urandom_range(0, 4))
        0:       send_item(1'b0, SERVO_LENGTH, 1'b0, NO_RESULT);
        1:       send_item(1'b0, TLM_LENGTH, 1'b0, NO_RESULT);
        2:       send_item(1'b0, WORD_HEADER, 1'b0, NO_RESULT);
        3:       send_item(1'b1, 8'($urandom), 1'b0, NO_RESULT);
        default: send_item(1'b0, 8'($urandom), 1'b0, NO_RESULT);
      endcase
    end

    // Final stretch at full speed on both sides with some gap in between.
    set_gap(8'($urandom_range(2, 6)));
    quiet_tail = 1'b1;
    run_random(24, predicted_results + 18);
    item_valid <= 1'b0;

    while (frame_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d requests (%0d ticks) and checked %0d results.",
             requests_taken, ticks_taken, results_checked);
    $display("Frames seen: %0d with a good checksum, %0d failed; gap settings 3, 255, 1, 0, %0d.",
             good_cnt, err_cnt, gap_cfg);
    if (fail_count == 0 && frame_results_due.size() == 0) begin
      $display("rc_serial_frame_receiver: match");
    end else begin
      $display("rc_serial_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule
